FILE: hw/rtl/tle_pkg.sv
// tle_pkg: shared types and constants for the tty line editor
// command codes, result kinds, control byte values and sizes
// no dependencies
`default_nettype none

package tle_pkg;

  // default line buffer size and width of the fill counter
  localparam int unsigned LINE_CAPACITY_DEF = 40;
  localparam int unsigned CNT_W             = 6;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QAW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // control bytes
  localparam logic [7:0] CH_EOT    = 8'd4;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_KILL   = 8'd21;
  localparam logic [7:0] CH_WERASE = 8'd23;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DEL    = 8'd127;

  // result kinds
  localparam logic [2:0] KIND_ECHO   = 3'd0;
  localparam logic [2:0] KIND_ERASE  = 3'd1;
  localparam logic [2:0] KIND_BELL   = 3'd2;
  localparam logic [2:0] KIND_REPLAY = 3'd3;
  localparam logic [2:0] KIND_NL     = 3'd4;
  localparam logic [2:0] KIND_FIN    = 3'd5;

  // classified command
  typedef enum logic [2:0] {
    OP_INSERT,
    OP_ERASE_CHAR,
    OP_ERASE_WORD,
    OP_KILL,
    OP_NEWLINE,
    OP_END
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tle_queue.sv
// tle_queue: small command queue between the decode front and the edit back
// depends on tle_pkg for the command type and depth
`default_nettype none

module tle_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  tle_pkg::cmd_t   wr_cmd,
  output logic            full,
  input  wire             pop,
  output tle_pkg::cmd_t   rd_cmd,
  output logic            not_empty
);
  import tle_pkg::*;

  cmd_t           entries [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full      = (count == (QAW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_cmd    = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tle_front.sv
// tle_front: accepts typed bytes and classifies them into edit commands
// depends on tle_pkg for control byte values and the command type
`default_nettype none

module tle_front (
  input  wire            s_tvalid,
  output logic           s_tready,
  input  wire [7:0]      s_tdata,   // [7:0] in_byte
  input  wire            s_tuser,   // [0] end_mark
  input  wire            q_full,
  output logic           push,
  output tle_pkg::cmd_t  cmd
);
  import tle_pkg::*;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // classify the byte; end of input wins over any byte value
  always_comb begin
    cmd.data = s_tdata;
    if (s_tuser) begin
      cmd.op = OP_END;
    end else begin
      case (s_tdata)
        CH_EOT:        cmd.op = OP_END;
        CH_NL:         cmd.op = OP_NEWLINE;
        CH_BS, CH_DEL: cmd.op = OP_ERASE_CHAR;
        CH_WERASE:     cmd.op = OP_ERASE_WORD;
        CH_KILL:       cmd.op = OP_KILL;
        default:       cmd.op = OP_INSERT;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tle_back.sv
// tle_back: executes edit commands on the line buffer, at most one result per cycle while the output is not stalled
// holds the line memory, fill count, finished flag and the output register
// depends on tle_pkg
`default_nettype none

module tle_back #(
  parameter int unsigned LINE_CAPACITY = tle_pkg::LINE_CAPACITY_DEF
) (
  input  wire            clk,
  input  wire            rst,
  input  tle_pkg::cmd_t  cmd,
  input  wire            cmd_valid,
  output logic           cmd_pop,
  output logic           m_tvalid,
  input  wire            m_tready,
  output logic [7:0]     m_tdata,   // [7:0] out_byte
  output logic [2:0]     m_tuser,   // [2:0] out_kind
  output logic           m_tlast    // [0] last
);
  import tle_pkg::*;

  localparam int unsigned AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REPLAY,
    S_NL,
    S_WSP,
    S_WNS,
    S_ERASE
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic             finished, finished_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] target, target_next;
  logic [CNT_W-1:0] idx_dec;

  logic [7:0]       line_mem [LINE_CAPACITY];
  logic [7:0]       rd_data;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;

  logic             out_free;
  logic             emit;
  logic [2:0]       emit_kind;
  logic [7:0]       emit_byte;
  logic             emit_last;

  assign out_free = !m_tvalid || m_tready;
  assign idx_dec  = idx_next - 1'b1;

  // edit sequencer
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    finished_next = finished;
    idx_next      = idx;
    target_next   = target;
    emit          = 1'b0;
    emit_kind     = KIND_ECHO;
    emit_byte     = 8'd0;
    emit_last     = 1'b0;
    wr_en         = 1'b0;
    cmd_pop       = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (finished) begin
            emit      = 1'b1;
            emit_kind = KIND_FIN;
            emit_last = 1'b1;
          end else begin
            case (cmd.op)
              OP_END: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                if (fill == '0) begin
                  emit_kind     = KIND_FIN;
                  finished_next = 1'b1;
                end else begin
                  emit_kind = KIND_BELL;
                end
              end
              OP_NEWLINE: begin
                if (fill == '0) begin
                  emit      = 1'b1;
                  emit_kind = KIND_NL;
                  emit_last = 1'b1;
                end else begin
                  idx_next   = '0;
                  state_next = S_REPLAY;
                end
              end
              OP_ERASE_CHAR: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                if (fill != '0) begin
                  emit_kind = KIND_ERASE;
                  fill_next = fill - 1'b1;
                end else begin
                  emit_kind = KIND_BELL;
                end
              end
              OP_ERASE_WORD: begin
                if (fill != '0) begin
                  idx_next   = fill;
                  state_next = S_WSP;
                end
              end
              OP_KILL: begin
                if (fill != '0) begin
                  target_next = '0;
                  state_next  = S_ERASE;
                end
              end
              OP_INSERT: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                if (fill < CAP) begin
                  wr_en     = 1'b1;
                  emit_kind = KIND_ECHO;
                  emit_byte = cmd.data;
                  fill_next = fill + 1'b1;
                end else begin
                  emit_kind = KIND_BELL;
                end
              end
              default: ;
            endcase
          end
        end
      end
      // replay stops in front of a zero byte or at the fill count
      S_REPLAY: begin
        if (out_free) begin
          emit = 1'b1;
          if (rd_data == 8'd0) begin
            emit_kind  = KIND_NL;
            emit_last  = 1'b1;
            fill_next  = '0;
            state_next = S_IDLE;
          end else begin
            emit_kind = KIND_REPLAY;
            emit_byte = rd_data;
            idx_next  = idx + 1'b1;
            if (idx + 1'b1 == fill) begin
              state_next = S_NL;
            end
          end
        end
      end
      S_NL: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_NL;
          emit_last  = 1'b1;
          fill_next  = '0;
          state_next = S_IDLE;
        end
      end
      // word erase scan: trailing spaces first
      S_WSP: begin
        if (rd_data == CH_SPACE) begin
          idx_next = idx - 1'b1;
          if (idx == CNT_W'(1)) begin
            target_next = '0;
            state_next  = S_ERASE;
          end
        end else begin
          state_next = S_WNS;
        end
      end
      // then the word itself, up to the next space or the line start
      S_WNS: begin
        if (rd_data != CH_SPACE) begin
          idx_next = idx - 1'b1;
          if (idx == CNT_W'(1)) begin
            target_next = '0;
            state_next  = S_ERASE;
          end
        end else begin
          target_next = idx;
          state_next  = S_ERASE;
        end
      end
      // erase down to the target count, one position per result
      S_ERASE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KIND_ERASE;
          fill_next = fill - 1'b1;
          if (fill - 1'b1 == target) begin
            emit_last  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // read address is taken from the next state so the data is ready when that state is entered
  always_comb begin
    case (state_next)
      S_REPLAY:     rd_addr = idx_next[AW-1:0];
      S_WSP, S_WNS: rd_addr = idx_dec[AW-1:0];
      default:      rd_addr = '0;
    endcase
  end

  // line memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[fill[AW-1:0]] <= cmd.data;
    end
    rd_data <= line_mem[rd_addr];
  end

  // state, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      finished <= 1'b0;
      idx      <= '0;
      target   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      finished <= finished_next;
      idx      <= idx_next;
      target   <= target_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_byte;
      m_tuser <= emit_kind;
      m_tlast <= emit_last;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tty_line_editor.sv
// tty_line_editor: terminal line editing on a byte stream
//
// Input stream s_*: one typed byte per transfer, s_tuser marks end of input.
// Output stream m_*: result transfers, m_tuser is the kind (echo, erase,
// bell, replayed byte, newline, finished), m_tdata the byte for echo and
// replay, m_tlast marks the final result of one input byte.
// A front stage decodes each byte into an edit command and parks it in a
// two-entry queue; the back stage runs commands against a line memory of
// LINE_CAPACITY bytes and drives a registered output.
// A single result passes through the queue and the output register; a kill
// or a newline on a non-empty line first enters its erase or replay state,
// and a word erase emits only after its scan. Results leave at most one per
// cycle while the output is not stalled; a kill gives one erase per stored
// byte, a newline on a non-empty line up to n replayed bytes and a newline,
// a word erase one result per erased position (n = stored bytes, at most LINE_CAPACITY).
// Ctrl-W and Ctrl-U on an empty line give no result.
// Reset empties the line and the queue and clears the finished flag.
// When the receiver stalls the output register holds, the back stops, and
// the queue fills; s_tready then drops until space frees up.
// depends on tle_pkg, tle_front, tle_queue, tle_back
`default_nettype none

module tty_line_editor #(
  parameter int unsigned LINE_CAPACITY = tle_pkg::LINE_CAPACITY_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [7:0]  s_tdata,   // [7:0] in_byte
  input  wire        s_tuser,   // [0] end_mark
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [2:0] m_tuser,   // [2:0] out_kind
  output logic       m_tlast    // [0] last
);
  import tle_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic push;
  logic q_full;
  logic q_not_empty;
  logic pop;

  // decode
  tle_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  // command queue
  tle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_cmd    (front_cmd),
    .full      (q_full),
    .pop       (pop),
    .rd_cmd    (queue_cmd),
    .not_empty (q_not_empty)
  );

  // edit engine
  tle_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (queue_cmd),
    .cmd_valid (q_not_empty),
    .cmd_pop   (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire
